/* design/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants for the buddy block allocator
// Holds operation codes, status codes, sequencer states and reset defaults.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int LOG_BLOCKS_DEF = 10;
	localparam logic [5:0] BASE_ORDER_RST = 6'd5;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_TOO_BIG = 2'd1,
		STAT_NO_FREE = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_A_SCAN,
		S_A_GETB,
		S_A_WRN,
		S_A_WRB,
		S_A_SPLIT,
		S_F_LOOP,
		S_F_CHK,
		S_F_WRP,
		S_F_RDN,
		S_F_WRN,
		S_F_WRBUD,
		S_P_HEAD,
		S_P_RDH,
		S_P_WRH,
		S_DONE
	} state_t;

endpackage

/* design/buddy_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator_core: binary buddy allocator
// Hands out and takes back power-of-two runs of minimum blocks in a heap.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with func (allocate or free),
//   size_order (log2 bytes) and block_index (free only). Each request gives
//   one result on out_valid/out_ready: status, granted_index, granted_level
//   and the allocated block count after the request.
//   The minimum-order register is written through cfg_we/cfg_wdata with no
//   wait; write it only while no request is in flight.
//   Requests run one at a time. Allocate: scans the levels upward; if every
//   list is empty it finishes with no free block, else it unlinks the head
//   of the first non-empty list, splits it down level by level and finishes.
//   Free: merges with the free buddy level by level, pushes the final block
//   onto its list and finishes. An order too large goes straight to finish.
//   Each step makes at most one access of the per-block record memory, whose
//   registered read sets the pace. After reset a clearing pass over all
//   2^LOG_BLOCKS records (1024 at default) initializes the record memory
//   with the whole heap as one free top block; in_ready stays low meanwhile.
//   A finished result waits in the output register; the next request is
//   taken and processed, and holds in its final step until that register
//   is taken.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core #(
	parameter int LOG_BLOCKS = bba_pkg::LOG_BLOCKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [5:0]                          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [5:0]                          size_order,
	input  logic [LOG_BLOCKS-1:0]               block_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic [LOG_BLOCKS-1:0]               granted_index,
	output logic [$clog2(LOG_BLOCKS+1)-1:0]     granted_level,
	output logic [LOG_BLOCKS:0]                 allocated_blocks
);
	import bba_pkg::*;

	// level field width and packed record: free tag, level, next, prev
	localparam int LW    = $clog2(LOG_BLOCKS + 1);
	localparam int ENT_W = 1 + LW + 2 * (LOG_BLOCKS + 1);

	// hold the configured minimum order
	logic [5:0] base_order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_order_q <= BASE_ORDER_RST;
		end else if (cfg_we) begin
			base_order_q <= cfg_wdata;
		end
	end

	logic                  mem_we;
	logic [LOG_BLOCKS-1:0] mem_waddr, mem_raddr;
	logic [ENT_W-1:0]      mem_wdata, mem_rdata;

	// sequencer: list heads, count and result register
	bba_ctrl #(
		.LOG_BLOCKS(LOG_BLOCKS),
		.LW(LW),
		.ENT_W(ENT_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.base_order(base_order_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.size_order(size_order),
		.block_index(block_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.granted_index(granted_index),
		.granted_level(granted_level),
		.allocated_blocks(allocated_blocks),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// per-block records: free tag, level and list links
	bba_mem #(
		.LOG_BLOCKS(LOG_BLOCKS),
		.ENT_W(ENT_W)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

/* design/bba_mem.sv */
// ----------------------------------------------------------------------------
// bba_mem: per-block record store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bba_mem #(
	parameter int LOG_BLOCKS = 10,
	parameter int ENT_W = 27
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [LOG_BLOCKS-1:0] waddr,
	input  logic [ENT_W-1:0]      wdata,
	input  logic [LOG_BLOCKS-1:0] raddr,
	output logic [ENT_W-1:0]      rdata
);
	import bba_pkg::*;

	localparam int DEPTH = 1 << LOG_BLOCKS;

	logic [ENT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/bba_ctrl.sv */
// ----------------------------------------------------------------------------
// bba_ctrl: allocate / free sequencer
// Walks the free lists through read-modify-write of the record store,
// keeps the list heads and the allocated count, and holds the result.
// ----------------------------------------------------------------------------
module bba_ctrl #(
	parameter int LOG_BLOCKS = 10,
	parameter int LW = 4,
	parameter int ENT_W = 27
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [5:0]            base_order,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	input  logic [5:0]            size_order,
	input  logic [LOG_BLOCKS-1:0] block_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [LOG_BLOCKS-1:0] granted_index,
	output logic [LW-1:0]         granted_level,
	output logic [LOG_BLOCKS:0]   allocated_blocks,
	output logic                  mem_we,
	output logic [LOG_BLOCKS-1:0] mem_waddr,
	output logic [ENT_W-1:0]      mem_wdata,
	output logic [LOG_BLOCKS-1:0] mem_raddr,
	input  logic [ENT_W-1:0]      mem_rdata
);
	import bba_pkg::*;

	localparam int L = LOG_BLOCKS;
	localparam logic [L:0] NIL = {1'b1, {L{1'b0}}};
	localparam logic [L:0] NUM = NIL;
	localparam logic [LW-1:0] TOP_LV = LW'(L);

	state_t state_q, state_d;

	logic [L:0]   fl_head [L+1];
	logic [L:0]   count_q;
	logic [LW-1:0] lv_q, j_q;
	logic [L-1:0] idx_q, b_q, bud_q;
	logic [L:0]   n_q, p_q, h_q;
	logic         func_q;
	status_t      stat_q;
	logic [L-1:0] clr_q;

	logic         out_valid_q;
	logic [1:0]   out_status_q;
	logic [L-1:0] out_idx_q;
	logic [LW-1:0] out_lev_q;
	logic [L:0]   out_cnt_q;

	// record fields of the last read
	logic          rd_free;
	logic [LW-1:0] rd_lvl;
	logic [L:0]    rd_nxt, rd_prv;
	assign rd_free = mem_rdata[ENT_W-1];
	assign rd_lvl  = mem_rdata[ENT_W-2 -: LW];
	assign rd_nxt  = mem_rdata[2*L+1 : L+1];
	assign rd_prv  = mem_rdata[L:0];

	// single read point on the list heads
	logic [LW-1:0] hsel;
	logic [L:0]    head_rd;
	assign hsel    = (state_q == S_A_SCAN || state_q == S_A_GETB) ? j_q : lv_q;
	assign head_rd = fl_head[hsel];

	// request decode
	logic [6:0]    ord_c, mo_c;
	logic          too_big;
	logic [LW-1:0] req_lv;
	logic [L:0]    req_sz;
	assign mo_c    = {1'b0, base_order};
	assign ord_c   = ({1'b0, size_order} < mo_c) ? mo_c : {1'b0, size_order};
	assign too_big = ord_c > (mo_c + 7'(L));
	assign req_lv  = LW'(ord_c - mo_c);
	assign req_sz  = (L+1)'(1) << req_lv;

	logic [LW-1:0] jm1;
	logic [L-1:0]  split_blk;
	logic [L-1:0]  bud_c;
	logic [L+1:0]  cnt_sum;
	logic [L:0]    alloc_sz;
	assign jm1       = j_q - LW'(1);
	assign split_blk = b_q + (L'(1) << jm1);
	assign bud_c     = idx_q ^ (L'(1) << lv_q);
	assign alloc_sz  = (L+1)'(1) << lv_q;
	assign cnt_sum   = {1'b0, count_q} + {1'b0, alloc_sz};

	logic accept, out_free;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q == '0) ? {1'b1, TOP_LV, NIL, NIL}
				                          : {1'b0, {LW{1'b0}}, NIL, NIL};
				if (clr_q == {L{1'b1}}) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (too_big) state_d = S_DONE;
					else if (func == FUNC_FREE) state_d = S_F_LOOP;
					else state_d = S_A_SCAN;
				end
			end
			S_A_SCAN: begin
				mem_raddr = head_rd[L-1:0];
				if (!head_rd[L]) state_d = S_A_GETB;
				else if (j_q == TOP_LV) state_d = S_DONE;
			end
			S_A_GETB: begin
				mem_raddr = rd_nxt[L-1:0];
				state_d   = rd_nxt[L] ? S_A_WRB : S_A_WRN;
			end
			S_A_WRN: begin
				mem_we    = 1'b1;
				mem_waddr = n_q[L-1:0];
				mem_wdata = {rd_free, rd_lvl, rd_nxt, NIL};
				state_d   = S_A_WRB;
			end
			S_A_WRB: begin
				mem_we    = 1'b1;
				mem_waddr = b_q;
				mem_wdata = {1'b0, lv_q, NIL, NIL};
				state_d   = S_A_SPLIT;
			end
			S_A_SPLIT: begin
				if (j_q > lv_q) begin
					mem_we    = 1'b1;
					mem_waddr = split_blk;
					mem_wdata = {1'b1, jm1, NIL, NIL};
				end else begin
					state_d = S_DONE;
				end
			end
			S_F_LOOP: begin
				mem_raddr = bud_c;
				state_d   = (lv_q == TOP_LV) ? S_P_HEAD : S_F_CHK;
			end
			S_F_CHK: begin
				mem_raddr = rd_prv[L] ? rd_nxt[L-1:0] : rd_prv[L-1:0];
				if (!rd_free || rd_lvl != lv_q) state_d = S_P_HEAD;
				else if (!rd_prv[L]) state_d = S_F_WRP;
				else if (!rd_nxt[L]) state_d = S_F_WRN;
				else state_d = S_F_WRBUD;
			end
			S_F_WRP: begin
				mem_we    = 1'b1;
				mem_waddr = p_q[L-1:0];
				mem_wdata = {rd_free, rd_lvl, n_q, rd_prv};
				state_d   = n_q[L] ? S_F_WRBUD : S_F_RDN;
			end
			S_F_RDN: begin
				mem_raddr = n_q[L-1:0];
				state_d   = S_F_WRN;
			end
			S_F_WRN: begin
				mem_we    = 1'b1;
				mem_waddr = n_q[L-1:0];
				mem_wdata = {rd_free, rd_lvl, rd_nxt, p_q};
				state_d   = S_F_WRBUD;
			end
			S_F_WRBUD: begin
				mem_we    = 1'b1;
				mem_waddr = bud_q;
				mem_wdata = {1'b0, lv_q, NIL, NIL};
				state_d   = S_F_LOOP;
			end
			S_P_HEAD: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = {1'b1, lv_q, head_rd, NIL};
				state_d   = head_rd[L] ? S_DONE : S_P_RDH;
			end
			S_P_RDH: begin
				mem_raddr = h_q[L-1:0];
				state_d   = S_P_WRH;
			end
			S_P_WRH: begin
				mem_we    = 1'b1;
				mem_waddr = h_q[L-1:0];
				mem_wdata = {rd_free, rd_lvl, rd_nxt, {1'b0, idx_q}};
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers: list heads, count, clear sweep, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= L; i++) begin
				fl_head[i] <= (i == L) ? '0 : NIL;
			end
			count_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) clr_q <= clr_q + L'(1);
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && !too_big && func == FUNC_FREE) begin
						count_q <= (count_q > req_sz) ? count_q - req_sz : '0;
					end
				end
				S_A_GETB: fl_head[j_q] <= rd_nxt;
				S_A_SPLIT: begin
					if (j_q > lv_q) begin
						fl_head[jm1] <= {1'b0, split_blk};
					end else begin
						count_q <= (cnt_sum > {1'b0, NUM}) ? NUM : cnt_sum[L:0];
					end
				end
				S_F_CHK: begin
					if (rd_free && rd_lvl == lv_q && rd_prv[L] &&
					    head_rd == {1'b0, bud_q}) begin
						fl_head[lv_q] <= rd_nxt;
					end
				end
				S_P_HEAD: fl_head[lv_q] <= {1'b0, idx_q};
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					func_q <= func;
					lv_q   <= req_lv;
					j_q    <= req_lv;
					idx_q  <= block_index;
					stat_q <= too_big ? STAT_TOO_BIG : STAT_OK;
				end
			end
			S_A_SCAN: begin
				if (!head_rd[L]) b_q <= head_rd[L-1:0];
				else if (j_q == TOP_LV) stat_q <= STAT_NO_FREE;
				else j_q <= j_q + LW'(1);
			end
			S_A_GETB: n_q <= rd_nxt;
			S_A_SPLIT: begin
				if (j_q > lv_q) j_q <= jm1;
			end
			S_F_LOOP: bud_q <= bud_c;
			S_F_CHK: begin
				p_q <= rd_prv;
				n_q <= rd_nxt;
			end
			S_F_WRBUD: begin
				if (bud_q < idx_q) idx_q <= bud_q;
				lv_q <= lv_q + LW'(1);
			end
			S_P_HEAD: h_q <= head_rd;
			S_DONE: begin
				if (out_free) begin
					out_status_q <= stat_q;
					out_cnt_q    <= count_q;
					if (stat_q != STAT_OK) begin
						out_idx_q <= '0;
						out_lev_q <= '0;
					end else if (func_q == FUNC_FREE) begin
						out_idx_q <= idx_q;
						out_lev_q <= lv_q;
					end else begin
						out_idx_q <= b_q;
						out_lev_q <= lv_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign granted_index    = out_idx_q;
	assign granted_level    = out_lev_q;
	assign allocated_blocks = out_cnt_q;

endmodule

/* dv/bba_grant_checker.sv */
// ----------------------------------------------------------------------------
// bba_grant_checker: result checker for the buddy block allocator
// Watches the request and result channels, predicts each result from its own
// copy of the heap and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module bba_grant_checker
	import bba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        func,
	input  logic [5:0]  size_order,
	input  logic [9:0]  block_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [9:0]  granted_index,
	input  logic [3:0]  granted_level,
	input  logic [10:0] allocated_blocks,
	output int          fail_count,
	output int          grants_pending
);

	localparam int LOGB  = 10;
	localparam int NBLK  = 1 << LOGB;
	localparam logic [10:0] NIL = 11'(NBLK);

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  index;
		logic [3:0]  level;
		logic [10:0] count;
	} grant_t;

	grant_t     grant_q[$];
	logic [5:0] min_ord;
	bit         free_tag[NBLK];
	logic [3:0] blk_level[NBLK];
	logic [10:0] next_blk[NBLK];
	logic [10:0] prev_blk[NBLK];
	logic [10:0] head[LOGB+1];
	logic [10:0] alloc_cnt;

	task automatic heap_reset();
		min_ord = BASE_ORDER_RST;
		for (int i = 0; i < NBLK; i++) begin
			free_tag[i] = 0;
			blk_level[i] = 0;
			next_blk[i] = NIL;
			prev_blk[i] = NIL;
		end
		for (int i = 0; i <= LOGB; i++)
			head[i] = NIL;
		head[LOGB] = 0;
		free_tag[0] = 1;
		blk_level[0] = 4'(LOGB);
		alloc_cnt = 0;
	endtask

	task automatic list_push(input logic [10:0] b, input int lv);
		logic [10:0] h;
		h = head[lv];
		next_blk[b] = h;
		prev_blk[b] = NIL;
		if (h != NIL)
			prev_blk[h] = b;
		head[lv] = b;
		blk_level[b] = 4'(lv);
		free_tag[b] = 1;
	endtask

	task automatic list_unlink(input logic [10:0] b);
		logic [10:0] p, n;
		int l;
		p = prev_blk[b];
		n = next_blk[b];
		l = blk_level[b];
		if (p != NIL)
			next_blk[p] = n;
		else if (l <= LOGB && head[l] == b)
			head[l] = n;
		if (n != NIL)
			prev_blk[n] = p;
		next_blk[b] = NIL;
		prev_blk[b] = NIL;
	endtask

	// Apply one request to the heap copy and queue the grant it must produce.
	task automatic predict_grant(input logic f, input logic [5:0] so, input logic [9:0] bi);
		int ord, mo, lv, j, sz, cnt_next;
		bit found, merging;
		logic [10:0] b, n, bud, idx;
		grant_t g;
		ord = so;
		mo = min_ord;
		idx = {1'b0, bi};
		g = '0;
		if (ord < mo)
			ord = mo;
		if (ord > mo + LOGB) begin
			g.status = STAT_TOO_BIG;
		end else begin
			lv = ord - mo;
			if (func_t'(f) == FUNC_ALLOC) begin
				g.status = STAT_NO_FREE;
				found = 0;
				for (j = lv; j <= LOGB && !found; j++) begin
					if (head[j] != NIL) begin
						b = head[j];
						n = next_blk[b];
						head[j] = n;
						if (n != NIL)
							prev_blk[n] = NIL;
						next_blk[b] = NIL;
						prev_blk[b] = NIL;
						free_tag[b] = 0;
						// split down, pushing each upper half
						while (j > lv) begin
							j--;
							list_push((b + (11'd1 << j)) & 11'(NBLK - 1), j);
						end
						blk_level[b] = 4'(lv);
						cnt_next = int'(alloc_cnt) + (1 << lv);
						alloc_cnt = (cnt_next > NBLK) ? 11'(NBLK) : 11'(cnt_next);
						g.status = STAT_OK;
						g.index = b[9:0];
						g.level = 4'(lv);
						found = 1;
					end
				end
			end else begin
				sz = 1 << lv;
				alloc_cnt = (alloc_cnt > sz) ? alloc_cnt - 11'(sz) : 11'd0;
				merging = 1;
				while (lv < LOGB && merging) begin
					bud = (idx ^ (11'd1 << lv)) & 11'(NBLK - 1);
					if (!free_tag[bud] || blk_level[bud] != lv) begin
						merging = 0;
					end else begin
						list_unlink(bud);
						free_tag[bud] = 0;
						if (bud < idx)
							idx = bud;
						lv++;
					end
				end
				list_push(idx, lv);
				g.index = idx[9:0];
				g.level = 4'(lv);
			end
		end
		g.count = alloc_cnt;
		grant_q.push_back(g);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t g;
		if (!arst_n) begin
			heap_reset();
			grant_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we)
				min_ord = cfg_wdata;
			if (in_valid && in_ready)
				predict_grant(func, size_order, block_index);
			if (out_valid && out_ready) begin
				if (grant_q.size() == 0) begin
					report_mismatch("unexpected result, queue depth", 0, 0);
				end else begin
					g = grant_q.pop_front();
					if (status !== g.status)
						report_mismatch("status", status, g.status);
					if (granted_index !== g.index)
						report_mismatch("granted_index", granted_index, g.index);
					if (granted_level !== g.level)
						report_mismatch("granted_level", granted_level, g.level);
					if (allocated_blocks !== g.count)
						report_mismatch("allocated_blocks", allocated_blocks, g.count);
				end
			end
		end
		grants_pending = grant_q.size();
	end

endmodule

/* dv/tb_buddy_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator_core: testbench for the buddy block allocator
// Drives directed and random allocate/free requests across several minimum
// order settings with random idling on both channels; a checker predicts each
// result.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator_core;
	import bba_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 100;
	localparam int STALL_CYCLES = 400;
	localparam int PHASE_ITEMS = 200;

	typedef struct {
		logic [9:0] index;
		logic [3:0] level;
	} live_blk_t;

	typedef struct {
		logic       f;
	} pend_req_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [5:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [5:0]  size_order;
	logic [9:0]  block_index;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [9:0]  granted_index;
	logic [3:0]  granted_level;
	logic [10:0] allocated_blocks;

	int        fail_count;
	int        grants_pending;
	int        cycles;
	int        cur_mo;
	bit        calm;       // no idling on either side while set
	bit        stall_req;  // toggle to ask the receiver for one long hold-off
	live_blk_t live_q[$];
	pend_req_t req_q[$];

	buddy_block_allocator_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .size_order(size_order), .block_index(block_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .granted_index(granted_index),
		.granted_level(granted_level), .allocated_blocks(allocated_blocks)
	);

	bba_grant_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .size_order(size_order), .block_index(block_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .granted_index(granted_index),
		.granted_level(granted_level), .allocated_blocks(allocated_blocks),
		.fail_count(fail_count), .grants_pending(grants_pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Track which blocks are held, so frees mostly return real allocations.
	always @(posedge clk) begin
		pend_req_t r;
		live_blk_t lb;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				r.f = func;
				req_q.push_back(r);
			end
			if (out_valid && out_ready && req_q.size() > 0) begin
				r = req_q.pop_front();
				if (func_t'(r.f) == FUNC_ALLOC && status_t'(status) == STAT_OK) begin
					lb.index = granted_index;
					lb.level = granted_level;
					live_q.push_back(lb);
				end
			end
		end
	end

	// Receiver: random ready, plus one long hold-off on request.
	always @(negedge clk) begin
		static int  hold_left = 0;
		static bit  stall_seen = 0;
		if (stall_req != stall_seen) begin
			stall_seen = stall_req;
			hold_left = STALL_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
		end
	end

	// Offer one request; hold it until accepted. Leaves valid high on return.
	task automatic send_request(input logic f, input logic [5:0] so, input logic [9:0] bi);
		while (!calm && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		size_order <= so;
		block_index <= bi;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Drop valid, wait for every grant, then let the block finish any tail.
	task automatic settle();
		in_valid <= 1'b0;
		while (grants_pending != 0 || req_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Return every held block to the heap.
	task automatic free_all_live();
		live_blk_t lb;
		settle();
		while (live_q.size() > 0) begin
			lb = live_q.pop_front();
			send_request(FUNC_FREE, 6'(lb.level + cur_mo), lb.index);
		end
		settle();
	endtask

	task automatic write_min_order(input logic [5:0] mo);
		cfg_we <= 1'b1;
		cfg_wdata <= mo;
		cur_mo = mo;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random request: mostly frees of held blocks and sized allocates,
	// with some stray frees and out-of-range orders as noise.
	task automatic random_request();
		int r, lv, k, so;
		live_blk_t lb;
		r = $urandom_range(99);
		if (live_q.size() > 0 && r < 45) begin
			k = $urandom_range(live_q.size() - 1);
			lb = live_q[k];
			live_q.delete(k);
			so = lb.level + cur_mo;
			// a level-zero free may give any order at or below the minimum
			if (lb.level == 0 && cur_mo > 0 && $urandom_range(1))
				so = $urandom_range(cur_mo);
			send_request(FUNC_FREE, 6'(so), lb.index);
		end else if (r < 49) begin
			send_request(FUNC_FREE, 6'($urandom_range(63)), 10'($urandom_range(1023)));
		end else begin
			lv = ($urandom_range(3) == 0) ? $urandom_range(10) : $urandom_range(3);
			so = cur_mo + lv;
			if ($urandom_range(9) == 0)
				so = $urandom_range(63);
			send_request(FUNC_ALLOC, 6'(so), 10'($urandom_range(1023)));
		end
	endtask

	initial begin
		int mo_list[6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		func = 1'b0;
		size_order = '0;
		block_index = '0;
		out_ready = 1'b0;
		cycles = 0;
		cur_mo = BASE_ORDER_RST;
		calm = 0;
		stall_req = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset minimum order, extremes of order and index.
		send_request(FUNC_ALLOC, 6'd0, 10'd1023);   // below minimum, level 0
		send_request(FUNC_ALLOC, 6'd63, 10'd0);     // order larger than heap
		send_request(FUNC_ALLOC, 6'd15, 10'd0);     // top level, heap now split
		send_request(FUNC_ALLOC, 6'd14, 10'd0);     // half heap
		send_request(FUNC_ALLOC, 6'd14, 10'd0);     // nothing left that big
		send_request(FUNC_FREE, 6'd63, 10'd1023);   // free with order too large
		free_all_live();                            // merge back to one block
		send_request(FUNC_ALLOC, 6'd15, 10'd0);     // whole heap, count saturated
		send_request(FUNC_ALLOC, 6'd5, 10'd0);      // nothing free at all
		free_all_live();
		send_request(FUNC_ALLOC, 6'd6, 10'd0);
		send_request(FUNC_ALLOC, 6'd5, 10'd0);
		send_request(FUNC_FREE, 6'd5, 10'd1023);    // stray free of a never-held block
		send_request(FUNC_FREE, 6'd5, 10'd1023);    // and again: double free
		send_request(FUNC_FREE, 6'd3, 10'd0);       // count falls to zero, clamped
		free_all_live();

		mo_list = '{0, 32, 5, 0, 0, 0};
		for (int p = 3; p < 6; p++)
			mo_list[p] = $urandom_range(32);
		for (int p = 0; p < 6; p++) begin
			free_all_live();
			write_min_order(6'(mo_list[p]));
			calm = (p == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 3 && i == 20)
					stall_req = ~stall_req;  // receiver holds off, input backs up
				if (p == 4 && i == 100)
					settle();                // sender pauses until all grants are back
				random_request();
			end
		end
		calm = 0;
		settle();

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
design/bba_pkg.sv
design/bba_mem.sv
design/bba_ctrl.sv
design/buddy_block_allocator_core.sv
dv/bba_grant_checker.sv
dv/tb_buddy_block_allocator_core.sv
